/* design/sorted_max_priority_queue_unit_assert.svh */
// Assertion macros for the sorted max priority queue.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef SORTED_MAX_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_MAX_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define SMPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/smpq_pkg.sv */
// Shared types and constants for the sorted max priority queue.
// No dependencies.
package smpq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic ins;
    logic rem;
    val_t value;
  } smpq_cmd_t;

endpackage

/* design/smpq_if.sv */
// Handshake channels of the sorted max priority queue: request and result.
// Depends on smpq_pkg.
interface smpq_in_if;
  import smpq_pkg::*;

  logic valid;
  logic ready;
  logic op;
  val_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface smpq_out_if;
  import smpq_pkg::*;

  logic              valid;
  logic              ready;
  val_t              max_value;
  logic [STAT_W-1:0] status;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, output max_value, output status, output fill_count,
                  input ready);
  modport sink (input valid, input max_value, input status, input fill_count,
                output ready);
endinterface

/* design/smpq_cell.sv */
// One storage cell of the sorted queue: holds one entry, trades with its neighbors.
// Depends on smpq_pkg.
module smpq_cell (
  input  logic               clk,
  input  smpq_pkg::smpq_cmd_t cmd,
  input  logic               own_vld,
  input  logic               left_keep,
  input  smpq_pkg::val_t     left_entry,
  input  smpq_pkg::val_t     right_entry,
  output smpq_pkg::val_t     entry,
  output logic               keep
);
  import smpq_pkg::*;

  val_t entry_r;
  val_t entry_nxt;

  assign keep  = own_vld && (entry_r > cmd.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (!keep) begin
        entry_nxt = left_keep ? cmd.value : left_entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* design/sorted_max_priority_queue_unit.sv */
// Sorted max priority queue: a row of DEPTH cells kept in descending order.
// The result of an accepted item is held in the output register from the cycle after it is accepted.
// Throughput: one item per cycle while the result side is ready; each cell compares and shifts in a single step.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
// Depends on smpq_pkg, smpq_if, smpq_cell and the assertion header.
`include "sorted_max_priority_queue_unit_assert.svh"

module sorted_max_priority_queue_unit (
  input logic        clk,
  input logic        rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);
  import smpq_pkg::*;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  val_t              max_r;
  logic [STAT_W-1:0] status_r;
  logic [FILL_W-1:0] fill_r;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  smpq_cmd_t         cmd;
  val_t              max_nxt;
  logic [STAT_W-1:0] status_nxt;

  val_t cell_val  [DEPTH];
  logic cell_keep [DEPTH];
  logic cell_vld  [DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == CNT_W'(DEPTH));
  assign is_empty    = (count_r == '0);

  assign cmd.ins   = accept && (in_ch.op == OP_INSERT) && !is_full;
  assign cmd.rem   = accept && (in_ch.op == OP_REMOVE) && !is_empty;
  assign cmd.value = in_ch.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_vld[i] = (count_r > CNT_W'(i));
    if (i == 0) begin : g_head
      smpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .own_vld     (cell_vld[i]),
        .left_keep   (1'b1),
        .left_entry  ('0),
        .right_entry (cell_val[i+1]),
        .entry       (cell_val[i]),
        .keep        (cell_keep[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      smpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .own_vld     (cell_vld[i]),
        .left_keep   (cell_keep[i-1]),
        .left_entry  (cell_val[i-1]),
        .right_entry ('0),
        .entry       (cell_val[i]),
        .keep        (cell_keep[i])
      );
    end else begin : g_mid
      smpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .own_vld     (cell_vld[i]),
        .left_keep   (cell_keep[i-1]),
        .left_entry  (cell_val[i-1]),
        .right_entry (cell_val[i+1]),
        .entry       (cell_val[i]),
        .keep        (cell_keep[i])
      );
    end
  end

  always_comb begin
    count_nxt  = count_r;
    max_nxt    = '0;
    status_nxt = ST_OK;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
      max_nxt   = cell_val[0];
    end else if (in_ch.op == OP_INSERT) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      max_r    <= max_nxt;
      status_r <= status_nxt;
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.max_value  = max_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_r;

  `SMPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `SMPQ_ASSERT_IMP(a_head_order, count_r >= CNT_W'(2), cell_val[0] >= cell_val[1], "head out of order")
  `SMPQ_ASSERT_NXT(a_insert_count, cmd.ins, count_r == $past(count_r) + CNT_W'(1), "insert count slip")
  `SMPQ_ASSERT_IMP(a_empty_zero, out_valid_r && status_r == ST_EMPTY, max_r == '0, "empty result nonzero")

endmodule

/* sim/smpq_result_checker.sv */
// Result checker for the sorted max priority queue: predicts every result from the
// accepted items and compares it with what the queue returns. Depends on smpq_pkg, smpq_if.
`timescale 1ns / 100ps

module smpq_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  smpq_in_if          in_mon,
  smpq_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned results_seen,
  output int unsigned ok_seen,
  output int unsigned empty_seen,
  output int unsigned full_seen,
  output int unsigned peak_fill
);
  import smpq_pkg::*;

  typedef struct packed {
    val_t              max_value;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
  } queue_result_t;

  val_t          held [DEPTH+1];
  int unsigned   held_count;
  queue_result_t awaited_q[$];

  function automatic queue_result_t apply_item(input logic op, input val_t value);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   i;
    r.max_value = '0;
    r.status    = ST_OK;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos] > value) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos] = value;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.max_value = held[0];
        for (i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
      end
    end
    r.fill_count = FILL_W'(held_count);
    return r;
  endfunction

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    ok_seen      = 0;
    empty_seen   = 0;
    full_seen    = 0;
    peak_fill    = 0;
    held_count   = 0;
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      held_count = 0;
      awaited_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        awaited_q.push_back(apply_item(in_mon.op, in_mon.value));
        if (held_count > peak_fill) peak_fill = held_count;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result with no item pending: max_value %0d status %0d fill_count %0d",
                 out_mon.max_value, out_mon.status, out_mon.fill_count);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          results_seen++;
          case (want.status)
            ST_EMPTY: empty_seen++;
            ST_FULL:  full_seen++;
            default:  ok_seen++;
          endcase
          if (out_mon.max_value !== want.max_value) begin
            $error("max_value: expected %0d, got %0d", want.max_value, out_mon.max_value);
            fail_count++;
          end
          if (out_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
            fail_count++;
          end
          if (out_mon.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, out_mon.fill_count);
            fail_count++;
          end
        end
      end
    end
    pending = awaited_q.size();
  end

endmodule

/* sim/tb_sorted_max_priority_queue_unit.sv */
// Testbench top for sorted_max_priority_queue_unit: directed and random insert/remove
// traffic with random stalls on both sides. Depends on smpq_pkg, smpq_if, smpq_result_checker.
`timescale 1ns / 100ps

module tb_sorted_max_priority_queue_unit;
  import smpq_pkg::*;

  localparam int IDLE_PCT    = 8;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 80;
  localparam int N_RANDOM    = 1030;
  localparam int DRAIN       = 10;
  localparam int STALL_LIMIT = 1000;

  logic clk;
  logic rst_n;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned ok_seen;
  int unsigned empty_seen;
  int unsigned full_seen;
  int unsigned peak_fill;

  int unsigned items_sent;
  int unsigned directed_items;
  int unsigned hold_left;
  bit          hold_done;
  bit          calm;

  sorted_max_priority_queue_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  smpq_result_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .ok_seen      (ok_seen),
    .empty_seen   (empty_seen),
    .full_seen    (full_seen),
    .peak_fill    (peak_fill)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic offer(input logic op, input val_t value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // result side: random stalls, one long hold to back the queue up
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    val_t        fill_vals [16];
    val_t        v;
    logic        op;
    int unsigned ins_pct;
    int unsigned n;
    int unsigned k;
    fill_vals = '{val_t'(32'h7fff_ffff), val_t'(32'h8000_0000), 0, -1, 1, 7, 7, 7, -7,
                  100, -100, val_t'(32'h7fff_fffe), val_t'(32'h8000_0001), 7, 0, -1};
    items_sent  = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    calm        = 1'b0;
    ins_pct     = 50;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_INSERT;
    in_ch.value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty remove, fill past full with extremes and duplicates, then pull a few back
    offer(OP_REMOVE, val_t'($urandom));
    for (k = 0; k < 16; k++) offer(OP_INSERT, fill_vals[k]);
    offer(OP_INSERT, 3);
    for (k = 0; k < 4; k++) offer(OP_REMOVE, val_t'($urandom));
    directed_items = items_sent;

    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 15;
          1:       ins_pct = 50;
          default: ins_pct = 85;
        endcase
      end
      calm = (n >= 400 && n < 600);
      op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(9)) inside
        [0:4]: v = val_t'($urandom);
        7: begin
          case ($urandom_range(3))
            0:       v = val_t'(32'h7fff_ffff);
            1:       v = val_t'(32'h8000_0000);
            2:       v = 0;
            default: v = -1;
          endcase
        end
        default: v = val_t'(int'($urandom_range(8)) - 4);
      endcase
      offer(op, v);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("summary: %0d items (%0d directed), %0d results checked, peak fill %0d of %0d",
             items_sent, directed_items, results_seen, peak_fill, DEPTH);
    $display("summary: %0d ok, %0d removes from empty, %0d inserts dropped when full",
             ok_seen, empty_seen, full_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
